// ===== src/mains_voltage_window_stats_macros.svh =====
// Assertion macros for the mains voltage window statistics block.
// Used by the top-level RTL file in this folder; each macro expects clk and arst_n in scope.
`ifndef MAINS_VOLTAGE_WINDOW_STATS_MACROS_SVH
`define MAINS_VOLTAGE_WINDOW_STATS_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MVWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MVWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mvws_pkg.sv =====
// Shared types, widths and constants for the mains voltage window statistics block.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package mvws_pkg;

	// Ring geometry.
	localparam int RING_DEPTH = 8192;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int TIME_W  = 32;
	localparam int VOLT_W  = 9;
	localparam int AVG_W   = 17;
	localparam int MIN_W   = 16;
	localparam int HELD_W  = 14;

	// Running sum and accumulated low time.
	localparam int SUM_W = VOLT_W + IDX_W;
	localparam int LOW_W = TIME_W + CNT_W;

	// Average divider sizes: scaled sum over the held count.
	localparam int DIV_W   = SUM_W + 8;
	localparam int DVS_W   = CNT_W;
	localparam int DCNT_W  = $clog2(DIV_W);

	// Minutes by reciprocal multiplication: 60000 is 1875 * 2^5, and
	// floor(x / 1875) equals (x * MINUTE_RECIP) >> 38 for every x below 2^27.
	localparam int MINUTE_SHIFT = 5;
	localparam int RECIP_SHIFT  = 38;
	localparam int RECIP_W      = 28;
	localparam logic [RECIP_W-1:0] MINUTE_RECIP = 28'd146601551;
	localparam int PROD_W       = TIME_W - MINUTE_SHIFT + RECIP_W;

	// Low time from which the minute count is held at its cap (65536 * 60000 ms).
	localparam logic [LOW_W-1:0] LOW_CAP_MS = LOW_W'(64'd3932160000);
	localparam logic [MIN_W-1:0] MINUTES_CAP = '1;

	// Register addresses (word index on paddr[3:2]).
	typedef enum logic [1:0] {
		REG_WINDOW   = 2'd0,
		REG_THRESH   = 2'd1,
		REG_NOMINAL  = 2'd2,
		REG_BASELINE = 2'd3
	} reg_idx_t;

	// Reset values of the registers.
	localparam logic [TIME_W-1:0] WINDOW_RST   = 32'd86400000;
	localparam logic [VOLT_W-1:0] THRESH_RST   = 9'd190;
	localparam logic [TIME_W-1:0] NOMINAL_RST  = 32'd10000;
	localparam logic [VOLT_W-1:0] BASELINE_RST = 9'd220;

	// One ring entry.
	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [VOLT_W-1:0] volts;
	} entry_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// Divider status.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DROP_RD,
		ST_DROP_UPD,
		ST_WRITE,
		ST_EV_RD,
		ST_EV_CHK,
		ST_WALK,
		ST_WALK_END,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_MIN_GO,
		ST_MIN_WAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== src/mvws_ring_mem.sv =====
// Ring storage for timestamp and voltage of each held reading.
// Depends on mvws_pkg; one write port and one registered read port.
`default_nettype none

module mvws_ring_mem (
	input  wire logic              clk,
	input  wire mvws_pkg::mem_req_t req,
	output logic [$bits(mvws_pkg::entry_t)-1:0] rdata
);
	import mvws_pkg::*;

	entry_t mem_q [RING_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Registered read port: data follows in the cycle after the request.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/mvws_divider.sv =====
// Restoring divider, one quotient bit per cycle, used for the window average.
// Depends on mvws_pkg for its widths.
`default_nettype none

module mvws_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [mvws_pkg::DIV_W-1:0] dividend,
	input  wire logic [mvws_pkg::DVS_W-1:0] divisor,
	output mvws_pkg::div_stat_t             stat,
	output logic [mvws_pkg::DIV_W-1:0]      quotient
);
	import mvws_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] step_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVS_W:0]    rem_sh;
	logic [DVS_W:0]    rem_sub;

	// Trial subtraction for the current bit.
	always_comb begin
		rem_sh  = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign stat     = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/mains_voltage_window_stats.sv =====
// Top level of the mains voltage window statistics block: registers, sequencer, datapath.
// Depends on mvws_pkg, mvws_ring_mem, mvws_divider and the assertion macro header.
`default_nettype none
`include "mains_voltage_window_stats_macros.svh"

// Each reading is written into an 8192-entry ring memory, readings older than
// window_ms are evicted from the oldest end, and the held readings are then
// walked once to form minimum, maximum and low-voltage time; a serial divider
// gives the average and a reciprocal multiplication gives the minute count.
// Every eviction check and every walk step goes through the single read port
// of the ring memory, and the average through the one-bit-per-cycle divider.
// A result that cannot leave because the previous one is still waiting holds
// the sequencer until the previous one is taken. The ring needs no clearing
// after reset. A new reading is accepted only while the block is idle; a
// finished result waits in the output register and does not hold up the next
// reading.
module mains_voltage_window_stats (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Reading input.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // timestamp_ms[31:0], voltage[40:32]
	// Result output.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,  // average_q8[16:0], minimum_volts[25:17],
	                                   // maximum_volts[34:26], minutes_below[50:35],
	                                   // held_count[64:51], oldest_dropped[65]
	// Configuration.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mvws_pkg::*;

	// Configuration registers.
	logic [TIME_W-1:0] window_q;
	logic [VOLT_W-1:0] thresh_q;
	logic [TIME_W-1:0] nominal_q;
	logic [VOLT_W-1:0] baseline_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	// Sequencer and ring state.
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  walk_q;
	logic [TIME_W-1:0] now_q;
	logic [VOLT_W-1:0] volts_q;
	logic              dropped_q;

	// Walk datapath.
	logic              rd_valid_s1;
	logic              first_s1;
	logic [VOLT_W-1:0] lo_q, hi_q;
	logic [LOW_W-1:0]  low_ms_q;
	logic              prev_low_q;
	logic [TIME_W-1:0] prev_time_q;
	entry_t            rd_entry;
	logic [TIME_W-1:0] gap;
	logic [TIME_W-1:0] gap_cap;
	logic              is_low;
	logic              evict;

	// Results and output register.
	logic [AVG_W-1:0]  avg_q;
	logic [PROD_W-1:0] minutes_prod_q;
	logic [MIN_W-1:0]  minutes_q;
	logic              out_valid_q;
	logic [71:0]       out_data_q;
	logic              out_load;

	// Memory and divider connections.
	mem_req_t          mem_req;
	logic [$bits(entry_t)-1:0] mem_rdata;
	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	div_stat_t         div_stat;
	logic [DIV_W-1:0]  div_quotient;

	mvws_ring_mem u_ring (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	mvws_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quotient)
	);

	// Configuration port: writes complete in the access cycle.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WINDOW_RST;
			thresh_q   <= THRESH_RST;
			nominal_q  <= NOMINAL_RST;
			baseline_q <= BASELINE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WINDOW:   window_q   <= pwdata;
				REG_THRESH:   thresh_q   <= pwdata[VOLT_W-1:0];
				REG_NOMINAL:  nominal_q  <= pwdata;
				REG_BASELINE: baseline_q <= pwdata[VOLT_W-1:0];
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW:   prdata = window_q;
			REG_THRESH:   prdata = 32'(thresh_q);
			REG_NOMINAL:  prdata = nominal_q;
			REG_BASELINE: prdata = 32'(baseline_q);
		endcase
	end

	// Decoded read data, eviction test and low-time terms.
	always_comb begin
		rd_entry = entry_t'(mem_rdata);
		evict    = (now_q - rd_entry.stamp) > window_q;
		is_low   = rd_entry.volts <= thresh_q;
		gap      = rd_entry.stamp - prev_time_q;
		gap_cap  = (gap < nominal_q) ? gap : nominal_q;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (cnt_q == CNT_W'(RING_DEPTH)) ? ST_DROP_RD : ST_WRITE;
				end
			end
			ST_DROP_RD:  state_d = ST_DROP_UPD;
			ST_DROP_UPD: state_d = ST_WRITE;
			ST_WRITE:    state_d = ST_EV_RD;
			ST_EV_RD:    state_d = ST_EV_CHK;
			ST_EV_CHK:   state_d = evict ? ST_EV_RD : ST_WALK;
			ST_WALK: begin
				if (walk_q == cnt_q - 1'b1) begin
					state_d = ST_WALK_END;
				end
			end
			ST_WALK_END: state_d = ST_AVG_GO;
			ST_AVG_GO:   state_d = ST_AVG_WAIT;
			ST_AVG_WAIT: state_d = div_stat.done ? ST_MIN_GO : ST_AVG_WAIT;
			ST_MIN_GO:   state_d = ST_MIN_WAIT;
			ST_MIN_WAIT: state_d = ST_DONE;
			ST_DONE:     state_d = (!out_valid_q || m_tready) ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Output logic of the sequencer: memory requests, divider start, handshakes.
	always_comb begin
		mem_req       = '0;
		mem_req.waddr = head_q + cnt_q[IDX_W-1:0];
		mem_req.wdata = '{stamp: now_q, volts: volts_q};
		mem_req.raddr = head_q;
		div_start     = 1'b0;
		div_dividend  = DIV_W'({sum_q, 8'd0});
		div_divisor   = DVS_W'(cnt_q);
		s_tready      = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:     s_tready = 1'b1;
			ST_DROP_RD:  mem_req.re = 1'b1;
			ST_WRITE:    mem_req.we = 1'b1;
			ST_EV_RD:    mem_req.re = 1'b1;
			ST_WALK: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = head_q + walk_q[IDX_W-1:0];
			end
			ST_AVG_GO:   div_start = 1'b1;
			ST_DONE:     out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// Sequencer state and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			walk_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					dropped_q <= 1'b0;
				end
				ST_DROP_UPD: begin
					sum_q     <= sum_q - SUM_W'(rd_entry.volts);
					head_q    <= head_q + 1'b1;
					cnt_q     <= cnt_q - 1'b1;
					dropped_q <= 1'b1;
				end
				ST_WRITE: begin
					sum_q <= sum_q + SUM_W'(volts_q);
					cnt_q <= cnt_q + 1'b1;
				end
				ST_EV_CHK: begin
					walk_q <= '0;
					if (evict) begin
						sum_q  <= sum_q - SUM_W'(rd_entry.volts);
						head_q <= head_q + 1'b1;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				ST_WALK: walk_q <= walk_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Capture of the accepted reading.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q   <= s_tdata[TIME_W-1:0];
			volts_q <= s_tdata[TIME_W +: VOLT_W];
		end
	end

	// Walk pipeline: read data arrives in the cycle after each request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			first_s1    <= 1'b0;
		end else begin
			rd_valid_s1 <= state_q == ST_WALK;
			first_s1    <= walk_q == '0;
		end
	end

	// Minimum, maximum (both seeded with the baseline) and low time over the held readings.
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			lo_q     <= baseline_q;
			hi_q     <= baseline_q;
			low_ms_q <= '0;
		end else if (rd_valid_s1) begin
			if (rd_entry.volts < lo_q) begin
				lo_q <= rd_entry.volts;
			end
			if (rd_entry.volts > hi_q) begin
				hi_q <= rd_entry.volts;
			end
			if (is_low && first_s1) begin
				low_ms_q <= low_ms_q + LOW_W'(nominal_q);
			end else if (is_low && prev_low_q) begin
				low_ms_q <= low_ms_q + LOW_W'(gap_cap);
			end
			prev_low_q  <= is_low;
			prev_time_q <= rd_entry.stamp;
		end
	end

	// Average from the divider; minutes from the reciprocal product, saturating
	// at the cap. Below the cap the low time fits in 32 bits.
	always_ff @(posedge clk) begin
		if (state_q == ST_AVG_WAIT && div_stat.done) begin
			avg_q <= div_quotient[AVG_W-1:0];
		end
		if (state_q == ST_MIN_GO) begin
			minutes_prod_q <= PROD_W'(low_ms_q[TIME_W-1:MINUTE_SHIFT])
				* PROD_W'(MINUTE_RECIP);
		end
		if (state_q == ST_MIN_WAIT) begin
			minutes_q <= (low_ms_q >= LOW_CAP_MS) ? MINUTES_CAP
				: minutes_prod_q[RECIP_SHIFT +: MIN_W];
		end
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, dropped_q, HELD_W'(cnt_q), minutes_q, hi_q, lo_q, avg_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks on the sequencer and ring bookkeeping.
	`MVWS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(RING_DEPTH), "ring count above depth")
	`MVWS_ASSERT_NEXT(a_write_nonempty, state_q == ST_WRITE, cnt_q != '0, "ring empty after write")
	`MVWS_ASSERT_NOW(a_result_nonempty, out_load, cnt_q != '0, "result with empty ring")
	`MVWS_ASSERT_NOW(a_div_free, div_start, !div_stat.busy, "divider started while busy")
	`MVWS_ASSERT_NOW(a_no_write_full, mem_req.we, cnt_q < CNT_W'(RING_DEPTH), "write into full ring")

endmodule

`default_nettype wire
